// File: rtl/core/kpv_pkg.sv
// ---------------------------------------------------------------------------
// kpv_pkg: shared types and helpers of the position/velocity filter
// Widths, operand and target codes, the micro-operation table that drives
// the serial multiply/divide sequencer, and the output saturation helpers.
// ---------------------------------------------------------------------------
package kpv_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned VarW     = 48;
  localparam int unsigned StepW    = 16;
  localparam int unsigned GateW    = 16;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned OpW      = 64;   // serial unit operand width
  localparam int unsigned ProdW    = 2 * OpW;
  localparam int unsigned CntW     = 6;    // counts the OpW serial steps
  localparam int unsigned AccW     = 66;   // working sums before clamping
  localparam int unsigned MagW     = 63;   // capped magnitude, up to 2^62
  localparam int unsigned InnW     = PosW + 1;
  localparam int unsigned SumW     = VarW + 1;
  localparam int unsigned OpIdxW   = 4;
  localparam int unsigned NumSrc   = 13;

  localparam logic [VarW-1:0]  VarFloor    = 48'd4295;
  localparam logic [VarW-1:0]  VarCeil     = 48'hFFFF_FFFF_FFFF;
  localparam logic [VarW-1:0]  AccelNzRst  = 48'd1073741824;
  localparam logic [VarW-1:0]  InitVarRst  = 48'h1_0000_0000;
  localparam logic [GateW-1:0] GateRst     = 16'd2304;
  localparam logic [StepW-1:0] StepMin     = 16'd105;
  localparam logic [StepW-1:0] StepMax     = 16'd52429;
  localparam logic [MagW-1:0]  MagCap      = 63'h4000_0000_0000_0000;

  localparam logic signed [AccW-1:0] PosHiA = 66'sd2147483647;
  localparam logic signed [AccW-1:0] PosLoA = -66'sd2147483648;
  localparam logic signed [AccW-1:0] VarHiA = 66'sd281474976710655;
  localparam logic signed [AccW-1:0] VarLoA = 66'sd4295;
  localparam logic signed [AccW-1:0] CovHiA = 66'sd140737488355327;
  localparam logic signed [AccW-1:0] CovLoA = -66'sd140737488355328;

  typedef enum logic [1:0] {
    MODE_PREDICT = 2'd0,
    MODE_POS     = 2'd1,
    MODE_VEL     = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ACCEL_NOISE = 2'd0,
    CFG_POS_DRIFT   = 2'd1,
    CFG_GATE        = 2'd2,
    CFG_INIT_VAR    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SRC_D, SRC_D2, SRC_VEL, SRC_ACC, SRC_COV, SRC_P11, SRC_PDN,
    SRC_ANV, SRC_INN, SRC_GATE, SRC_S, SRC_A, SRC_R
  } src_e;

  typedef enum logic [2:0] {
    K_RAW, K_SH19, K_SH20, K_SH40, K_SH41, K_DIV
  } kind_e;

  typedef enum logic [3:0] {
    T_POS, T_VEL, T_P00, T_P01, T_P11, T_D2, T_LHS, T_RHS,
    T_XM, T_XO, T_VM, T_VO
  } tgt_e;

  typedef struct packed {
    src_e  a;
    src_e  b;
    kind_e kind;
    logic  neg;    // negate the signed result
    logic  set;    // overwrite the target instead of adding to it
    tgt_e  tgt;
    logic  last;
  } op_t;

  // One multiply (and optional divide by S) per entry. Predictions grow the
  // state and covariance; corrections first build the gate compare.
  function automatic op_t op_desc(input logic corr, input logic [OpIdxW-1:0] idx);
    op_t o;
    o = '{SRC_D, SRC_D, K_RAW, 1'b0, 1'b0, T_D2, 1'b1};
    if (!corr) begin
      case (idx)
        4'd0: o = '{SRC_D,   SRC_D,  K_RAW,  1'b0, 1'b0, T_D2,  1'b0};
        4'd1: o = '{SRC_VEL, SRC_D,  K_SH20, 1'b0, 1'b0, T_POS, 1'b0};
        4'd2: o = '{SRC_ACC, SRC_D2, K_SH41, 1'b0, 1'b0, T_POS, 1'b0};
        4'd3: o = '{SRC_ACC, SRC_D,  K_SH20, 1'b0, 1'b0, T_VEL, 1'b0};
        4'd4: o = '{SRC_COV, SRC_D,  K_SH19, 1'b0, 1'b0, T_P00, 1'b0};
        4'd5: o = '{SRC_P11, SRC_D2, K_SH40, 1'b0, 1'b0, T_P00, 1'b0};
        4'd6: o = '{SRC_PDN, SRC_D,  K_SH20, 1'b0, 1'b0, T_P00, 1'b0};
        4'd7: o = '{SRC_P11, SRC_D,  K_SH20, 1'b0, 1'b0, T_P01, 1'b0};
        4'd8: o = '{SRC_ANV, SRC_D,  K_SH20, 1'b0, 1'b0, T_P11, 1'b1};
        default: o = '{SRC_D, SRC_D, K_RAW, 1'b0, 1'b0, T_D2, 1'b1};
      endcase
    end else begin
      case (idx)
        4'd0: o = '{SRC_INN,  SRC_INN, K_RAW, 1'b0, 1'b0, T_LHS, 1'b0};
        4'd1: o = '{SRC_GATE, SRC_S,   K_RAW, 1'b0, 1'b0, T_RHS, 1'b0};
        4'd2: o = '{SRC_A,    SRC_INN, K_DIV, 1'b0, 1'b0, T_XM,  1'b0};
        4'd3: o = '{SRC_COV,  SRC_INN, K_DIV, 1'b0, 1'b0, T_XO,  1'b0};
        4'd4: o = '{SRC_COV,  SRC_COV, K_DIV, 1'b1, 1'b0, T_VO,  1'b0};
        4'd5: o = '{SRC_A,    SRC_R,   K_DIV, 1'b0, 1'b1, T_VM,  1'b0};
        4'd6: o = '{SRC_COV,  SRC_R,   K_DIV, 1'b0, 1'b1, T_P01, 1'b1};
        default: o = '{SRC_D, SRC_D, K_RAW, 1'b0, 1'b0, T_D2, 1'b1};
      endcase
    end
    return o;
  endfunction

  function automatic logic [PosW-1:0] sat_pos(input logic signed [AccW-1:0] x);
    logic [PosW-1:0] r;
    if (x > PosHiA) r = {1'b0, {(PosW-1){1'b1}}};
    else if (x < PosLoA) r = {1'b1, {(PosW-1){1'b0}}};
    else r = x[PosW-1:0];
    return r;
  endfunction

  function automatic logic [VarW-1:0] sat_var(input logic signed [AccW-1:0] x);
    logic [VarW-1:0] r;
    if (x > VarHiA) r = VarCeil;
    else if (x < VarLoA) r = VarFloor;
    else r = x[VarW-1:0];
    return r;
  endfunction

  function automatic logic [VarW-1:0] sat_cov(input logic signed [AccW-1:0] x);
    logic [VarW-1:0] r;
    if (x > CovHiA) r = {1'b0, {(VarW-1){1'b1}}};
    else if (x < CovLoA) r = {1'b1, {(VarW-1){1'b0}}};
    else r = x[VarW-1:0];
    return r;
  endfunction

endpackage

// File: rtl/core/kalman_axis_pos_vel_filter_unit.sv
// ---------------------------------------------------------------------------
// kalman_axis_pos_vel_filter_unit: one-axis position/velocity Kalman filter
// A prediction and an accepted correction run the whole operation table; a
// gated-out correction stops after the gate compare; an unused mode skips both.
// One item at a time; the bit-serial 64x64 multiplier and 128/64 divider
// (one bit per cycle) set the rate. A finished beat waits in an output
// register while the next item is taken. Reset is asynchronous, active low.
// ---------------------------------------------------------------------------
module kalman_axis_pos_vel_filter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kpv_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [kpv_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kpv_pkg::ModeW-1:0]        mode_i,
  input  logic signed [kpv_pkg::PosW-1:0]  value_i,
  input  logic [kpv_pkg::StepW-1:0]        step_time_i,
  input  logic [kpv_pkg::VarW-1:0]         meas_var_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [kpv_pkg::PosW-1:0]  pos_est_o,
  output logic signed [kpv_pkg::PosW-1:0]  vel_est_o,
  output logic [kpv_pkg::VarW-1:0]         pos_var_out_o,
  output logic [kpv_pkg::VarW-1:0]         vel_var_out_o,
  output logic                             accepted_o
);
  import kpv_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PREP   = 8'b0000_0010,
    ST_LOAD   = 8'b0000_0100,
    ST_MUL    = 8'b0000_1000,
    ST_DIV    = 8'b0001_0000,
    ST_APPLY  = 8'b0010_0000,
    ST_COMMIT = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  localparam logic [CntW-1:0] CntLast = CntW'(OpW - 1);

  // Control and filter state.
  state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [OpIdxW-1:0] op_idx_q, op_idx_d;
  logic out_valid_q, out_valid_d;
  logic ok_q, ok_d;
  logic [VarW-1:0]  anv_q, anv_d, pdn_q, pdn_d;
  logic [GateW-1:0] gate_q, gate_d;
  logic signed [PosW-1:0] pos_q, pos_d, vel_q, vel_d;
  logic [VarW-1:0]  p00_q, p00_d, p11_q, p11_d;
  logic signed [VarW-1:0] p01_q, p01_d;

  // Item and datapath registers.
  mode_e mode_q, mode_d;
  logic signed [PosW-1:0] val_q, val_d;
  logic [StepW-1:0] d_q, d_d;
  logic [VarW-1:0]  r_q, r_d;
  logic signed [InnW-1:0] inn_q, inn_d;
  logic [SumW-1:0]  s_q, s_d;
  logic signed [AccW-1:0] tpos_q, tpos_d, tvel_q, tvel_d;
  logic signed [AccW-1:0] tp00_q, tp00_d, tp01_q, tp01_d, tp11_q, tp11_d;
  logic [PosW-1:0]  d2_q, d2_d;
  logic [OpW-1:0]   lhs_q, lhs_d;
  logic [OpW-1:0]   mula_q, mula_d, mulb_q, mulb_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic sign_q, sign_d, dsat_q, dsat_d;
  logic signed [PosW-1:0] pos_out_q, pos_out_d, vel_out_q, vel_out_d;
  logic [VarW-1:0]  pvar_out_q, pvar_out_d, vvar_out_q, vvar_out_d;
  logic acc_out_q, acc_out_d;

  // Combinational helpers.
  logic corr, vmeas, in_acc, out_acc, reject;
  op_t  op;
  tgt_e tgt;
  logic [OpW-1:0] src_mag [NumSrc];
  logic           src_neg [NumSrc];
  logic [PosW-1:0] vel_mag, acc_mag;
  logic [VarW-1:0] cov_mag, a_old;
  logic [InnW-1:0] inn_mag;
  logic signed [PosW-1:0] xm_old;
  logic [OpW:0]    mul_sum;
  logic [OpW:0]    div_t, div_s, div_diff;
  logic            div_ge;
  logic [ProdW-1:0] shifted;
  logic [MagW-1:0] cap_sh, cap_div, mag_res;
  logic [OpW-1:0]  rnd;
  logic [StepW-1:0] step_sat;
  logic [VarW-1:0] iv_new;
  logic signed [AccW-1:0] dlt;

  assign corr    = (mode_q != MODE_PREDICT);
  assign vmeas   = (mode_q == MODE_VEL);
  assign op      = op_desc(corr, op_idx_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  assign vel_mag = vel_q[PosW-1] ? (~vel_q + 1'b1) : vel_q;
  assign acc_mag = val_q[PosW-1] ? (~val_q + 1'b1) : val_q;
  assign cov_mag = p01_q[VarW-1] ? (~p01_q + 1'b1) : p01_q;
  assign inn_mag = inn_q[InnW-1] ? (~inn_q + 1'b1) : inn_q;
  assign a_old   = vmeas ? p11_q : p00_q;
  assign xm_old  = vmeas ? vel_q : pos_q;

  always_comb begin
    step_sat = step_time_i;
    if (step_time_i < StepMin) step_sat = StepMin;
    if (step_time_i > StepMax) step_sat = StepMax;
    iv_new = (cfg_wdata_i[VarW-1:0] < VarFloor) ? VarFloor : cfg_wdata_i[VarW-1:0];
  end

  always_comb begin
    src_mag[SRC_D]    = OpW'(d_q);
    src_mag[SRC_D2]   = OpW'(d2_q);
    src_mag[SRC_VEL]  = OpW'(vel_mag);
    src_mag[SRC_ACC]  = OpW'(acc_mag);
    src_mag[SRC_COV]  = OpW'(cov_mag);
    src_mag[SRC_P11]  = OpW'(p11_q);
    src_mag[SRC_PDN]  = OpW'(pdn_q);
    src_mag[SRC_ANV]  = OpW'(anv_q);
    src_mag[SRC_INN]  = OpW'(inn_mag);
    src_mag[SRC_GATE] = OpW'(gate_q);
    src_mag[SRC_S]    = OpW'(s_q);
    src_mag[SRC_A]    = OpW'(a_old);
    src_mag[SRC_R]    = OpW'(r_q);
    src_neg[SRC_D]    = 1'b0;
    src_neg[SRC_D2]   = 1'b0;
    src_neg[SRC_VEL]  = vel_q[PosW-1];
    src_neg[SRC_ACC]  = val_q[PosW-1];
    src_neg[SRC_COV]  = p01_q[VarW-1];
    src_neg[SRC_P11]  = 1'b0;
    src_neg[SRC_PDN]  = 1'b0;
    src_neg[SRC_ANV]  = 1'b0;
    src_neg[SRC_INN]  = inn_q[InnW-1];
    src_neg[SRC_GATE] = 1'b0;
    src_neg[SRC_S]    = 1'b0;
    src_neg[SRC_A]    = 1'b0;
    src_neg[SRC_R]    = 1'b0;
  end

  // Correction targets follow the measured quantity.
  always_comb begin
    case (op.tgt)
      T_XM:    tgt = vmeas ? T_VEL : T_POS;
      T_XO:    tgt = vmeas ? T_POS : T_VEL;
      T_VM:    tgt = vmeas ? T_P11 : T_P00;
      T_VO:    tgt = vmeas ? T_P00 : T_P11;
      default: tgt = op.tgt;
    endcase
  end

  // The rounding term is preloaded into the upper half of the product, so
  // the serial multiply delivers A*B plus that term.
  always_comb begin
    case (op.kind)
      K_SH19:  rnd = OpW'(1) << 18;
      K_SH20:  rnd = OpW'(1) << 19;
      K_SH40:  rnd = OpW'(1) << 39;
      K_SH41:  rnd = OpW'(1) << 40;
      K_DIV:   rnd = OpW'(s_q >> 1);
      default: rnd = '0;
    endcase
  end

  assign mul_sum  = {1'b0, prod_q[ProdW-1:OpW]} + {1'b0, mula_q};
  assign div_t    = prod_q[ProdW-1:OpW-1];
  assign div_s    = (OpW+1)'(s_q);
  assign div_ge   = (div_t >= div_s);
  assign div_diff = div_t - div_s;

  always_comb begin
    case (op.kind)
      K_SH19:  shifted = prod_q >> 19;
      K_SH20:  shifted = prod_q >> 20;
      K_SH40:  shifted = prod_q >> 40;
      K_SH41:  shifted = prod_q >> 41;
      default: shifted = prod_q;
    endcase
    cap_sh  = (|shifted[ProdW-1:MagW-1]) ? MagCap : {1'b0, shifted[MagW-2:0]};
    cap_div = (dsat_q || (|prod_q[OpW-1:MagW-1])) ? MagCap : {1'b0, prod_q[MagW-2:0]};
    mag_res = (op.kind == K_DIV) ? cap_div : cap_sh;
    dlt     = sign_q ? -$signed(AccW'(mag_res)) : $signed(AccW'(mag_res));
  end

  always_comb begin
    state_d = state_q;   cnt_d = cnt_q;       op_idx_d = op_idx_q;
    ok_d = ok_q;         anv_d = anv_q;       pdn_d = pdn_q;
    gate_d = gate_q;     pos_d = pos_q;       vel_d = vel_q;
    p00_d = p00_q;       p01_d = p01_q;       p11_d = p11_q;
    mode_d = mode_q;     val_d = val_q;       d_d = d_q;
    r_d = r_q;           inn_d = inn_q;       s_d = s_q;
    tpos_d = tpos_q;     tvel_d = tvel_q;     tp00_d = tp00_q;
    tp01_d = tp01_q;     tp11_d = tp11_q;     d2_d = d2_q;
    lhs_d = lhs_q;       mula_d = mula_q;     mulb_d = mulb_q;
    prod_d = prod_q;     sign_d = sign_q;     dsat_d = dsat_q;
    pos_out_d = pos_out_q;   vel_out_d = vel_out_q;
    pvar_out_d = pvar_out_q; vvar_out_d = vvar_out_q;
    acc_out_d = acc_out_q;
    out_valid_d = out_valid_q && !out_acc;
    reject = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_d  = mode_e'(mode_i);
          val_d   = value_i;
          d_d     = step_sat;
          r_d     = meas_var_i;
          ok_d    = 1'b1;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        inn_d    = {val_q[PosW-1], val_q} - {xm_old[PosW-1], xm_old};
        s_d      = {1'b0, a_old} + {1'b0, r_q};
        tpos_d   = AccW'(pos_q);
        tvel_d   = AccW'(vel_q);
        tp00_d   = $signed(AccW'(p00_q));
        tp01_d   = AccW'(p01_q);
        tp11_d   = $signed(AccW'(p11_q));
        op_idx_d = '0;
        if (mode_q == MODE_NONE) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mula_d  = src_mag[op.a];
        mulb_d  = src_mag[op.b];
        sign_d  = src_neg[op.a] ^ src_neg[op.b] ^ op.neg;
        prod_d  = {rnd, {OpW{1'b0}}};
        dsat_d  = 1'b0;
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = mulb_q[0] ? {mul_sum, prod_q[OpW-1:1]} : {1'b0, prod_q[ProdW-1:1]};
        mulb_d = mulb_q >> 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = (op.kind == K_DIV) ? ST_DIV : ST_APPLY;
        end
      end
      ST_DIV: begin
        // A quotient of 2^64 or more is caught before the first step.
        if (cnt_q == '0 && prod_q[ProdW-1:OpW] >= OpW'(s_q)) begin
          dsat_d  = 1'b1;
          state_d = ST_APPLY;
        end else begin
          prod_d = {(div_ge ? div_diff[OpW-1:0] : div_t[OpW-1:0]),
                    prod_q[OpW-2:0], div_ge};
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == CntLast) state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        case (tgt)
          T_POS: tpos_d = op.set ? dlt : tpos_q + dlt;
          T_VEL: tvel_d = op.set ? dlt : tvel_q + dlt;
          T_P00: tp00_d = op.set ? dlt : tp00_q + dlt;
          T_P01: tp01_d = op.set ? dlt : tp01_q + dlt;
          T_P11: tp11_d = op.set ? dlt : tp11_q + dlt;
          T_D2:  d2_d   = prod_q[PosW-1:0];
          T_LHS: lhs_d  = prod_q[OpW-1:0];
          T_RHS: reject = ({lhs_q, 8'd0} > (OpW+8)'(prod_q[OpW:0]));
          default: ;
        endcase
        op_idx_d = OpIdxW'(op_idx_q + 1'b1);
        if (reject) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else if (op.last) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_COMMIT: begin
        pos_d   = sat_pos(tpos_q);
        vel_d   = sat_pos(tvel_q);
        p00_d   = sat_var(tp00_q);
        p01_d   = sat_cov(tp01_q);
        p11_d   = sat_var(tp11_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          pos_out_d   = pos_q;
          vel_out_d   = vel_q;
          pvar_out_d  = p00_q;
          vvar_out_d  = p11_q;
          acc_out_d   = ok_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_NOISE: anv_d  = cfg_wdata_i[VarW-1:0];
        CFG_POS_DRIFT:   pdn_d  = cfg_wdata_i[VarW-1:0];
        CFG_GATE:        gate_d = cfg_wdata_i[GateW-1:0];
        CFG_INIT_VAR: begin
          p00_d = iv_new;
          p11_d = iv_new;
          p01_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      op_idx_q    <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      anv_q       <= AccelNzRst;
      pdn_q       <= '0;
      gate_q      <= GateRst;
      pos_q       <= '0;
      vel_q       <= '0;
      p00_q       <= InitVarRst;
      p01_q       <= '0;
      p11_q       <= InitVarRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      op_idx_q    <= op_idx_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      anv_q       <= anv_d;
      pdn_q       <= pdn_d;
      gate_q      <= gate_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      p00_q       <= p00_d;
      p01_q       <= p01_d;
      p11_q       <= p11_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    val_q      <= val_d;
    d_q        <= d_d;
    r_q        <= r_d;
    inn_q      <= inn_d;
    s_q        <= s_d;
    tpos_q     <= tpos_d;
    tvel_q     <= tvel_d;
    tp00_q     <= tp00_d;
    tp01_q     <= tp01_d;
    tp11_q     <= tp11_d;
    d2_q       <= d2_d;
    lhs_q      <= lhs_d;
    mula_q     <= mula_d;
    mulb_q     <= mulb_d;
    prod_q     <= prod_d;
    sign_q     <= sign_d;
    dsat_q     <= dsat_d;
    pos_out_q  <= pos_out_d;
    vel_out_q  <= vel_out_d;
    pvar_out_q <= pvar_out_d;
    vvar_out_q <= vvar_out_d;
    acc_out_q  <= acc_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pos_est_o     = pos_out_q;
  assign vel_est_o     = vel_out_q;
  assign pos_var_out_o = pvar_out_q;
  assign vel_var_out_o = vvar_out_q;
  assign accepted_o    = acc_out_q;

endmodule

// File: verif/kalman_axis_pos_vel_filter_unit_checker.sv
// ---------------------------------------------------------------------------
// kalman_axis_pos_vel_filter_unit_checker: scoreboard of the axis filter
// Watches the configuration port and both beat channels, keeps its own
// fixed-point copy of the filter state and compares every result beat.
// ---------------------------------------------------------------------------
module kalman_axis_pos_vel_filter_unit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kpv_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [kpv_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [kpv_pkg::ModeW-1:0]        mode_i,
  input  logic signed [kpv_pkg::PosW-1:0]  value_i,
  input  logic [kpv_pkg::StepW-1:0]        step_time_i,
  input  logic [kpv_pkg::VarW-1:0]         meas_var_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic signed [kpv_pkg::PosW-1:0]  pos_est_i,
  input  logic signed [kpv_pkg::PosW-1:0]  vel_est_i,
  input  logic [kpv_pkg::VarW-1:0]         pos_var_out_i,
  input  logic [kpv_pkg::VarW-1:0]         vel_var_out_i,
  input  logic                             accepted_i,
  output int                               pending_o,
  output int                               errors_o
);
  import kpv_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [PosW-1:0] vel;
    logic [VarW-1:0] pos_var;
    logic [VarW-1:0] vel_var;
    logic            ok;
  } estimate_t;

  localparam longint I32Min = -64'sd2147483648;
  localparam longint I32Max = 64'sd2147483647;
  localparam longint VMin   = 64'sd4295;
  localparam longint VMax   = 64'sd281474976710655;
  localparam longint CMax   = 64'sd140737488355327;
  localparam longint CMin   = -64'sd140737488355328;

  estimate_t estimate_q[$];
  int        errors;

  logic [VarW-1:0]  accel_noise, drift_noise;
  logic [GateW-1:0] gate;
  longint           pos_q, vel_q, p00_q, p01_q, p11_q;

  assign pending_o = estimate_q.size();
  assign errors_o  = errors;

  function automatic logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  // round(a*b / 2^n), saturating at 64 bits
  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int n);
    logic [127:0] w;
    w = wide_mul(a, b) + (128'd1 << (n - 1));
    w = w >> n;
    if (w[127:64] != 0) return '1;
    return w[63:0];
  endfunction

  // round(num / d), saturating
  function automatic logic [63:0] div_round(logic [127:0] num, logic [63:0] d);
    logic [127:0] q;
    if (d == 0) return '1;
    num = num + {64'd0, d >> 1};
    if (num[127:64] >= d) return '1;
    q = num / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic logic [63:0] magn(longint x);
    logic [63:0] u;
    u = x;
    return (x < 0) ? 64'd0 - u : u;
  endfunction

  function automatic longint signed_cap(logic neg, logic [63:0] m);
    if (m > 64'h4000_0000_0000_0000) m = 64'h4000_0000_0000_0000;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint smul(longint a, logic [63:0] b, int n);
    return signed_cap(a < 0, mul_round(magn(a), b, n));
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint gain_term(longint coef, longint innov, logic [63:0] s);
    return signed_cap((coef < 0) != (innov < 0), div_round(wide_mul(magn(coef), magn(innov)), s));
  endfunction

  function automatic void propagate(longint accel, logic [63:0] d);
    logic [63:0] d2;
    longint      p00, p01, p11;
    d2  = d * d;
    p00 = p00_q;
    p01 = p01_q;
    p11 = p11_q;
    pos_q = clip(pos_q + smul(vel_q, d, 20) + smul(accel, d2, 41), I32Min, I32Max);
    vel_q = clip(vel_q + smul(accel, d, 20), I32Min, I32Max);
    p00_q = clip(p00 + smul(p01, d, 19) + longint'(mul_round(p11, d2, 40))
                 + longint'(mul_round(drift_noise, d, 20)), VMin, VMax);
    p01_q = clip(p01 + longint'(mul_round(p11, d, 20)), CMin, CMax);
    p11_q = clip(p11 + longint'(mul_round(accel_noise, d, 20)), VMin, VMax);
  endfunction

  function automatic logic measure(logic on_vel, longint z, logic [63:0] r);
    longint       xm, xo, a, vo, c, innov, sq_s;
    logic [63:0]  s, im, sq;
    logic [127:0] lhs, rhs;
    xm = on_vel ? vel_q : pos_q;
    xo = on_vel ? pos_q : vel_q;
    a  = on_vel ? p11_q : p00_q;
    vo = on_vel ? p00_q : p11_q;
    c  = p01_q;
    innov = z - xm;
    s   = a + r;
    im  = magn(innov);
    lhs = {64'd0, im * im} << 8;
    rhs = wide_mul({48'd0, gate}, s);
    if (lhs > rhs) return 1'b0;
    xm = clip(xm + gain_term(a, innov, s), I32Min, I32Max);
    xo = clip(xo + gain_term(c, innov, s), I32Min, I32Max);
    sq = div_round(wide_mul(magn(c), magn(c)), s);
    if (sq > 64'h4000_0000_0000_0000) sq = 64'h4000_0000_0000_0000;
    sq_s = sq;
    vo = clip(vo - sq_s, VMin, VMax);
    a  = clip(longint'(div_round(wide_mul(a, r), s)), VMin, VMax);
    c  = clip(gain_term(c, longint'(r), s), CMin, CMax);
    if (on_vel) begin
      vel_q = xm; pos_q = xo; p11_q = a; p00_q = vo;
    end else begin
      pos_q = xm; vel_q = xo; p00_q = a; p11_q = vo;
    end
    p01_q = c;
    return 1'b1;
  endfunction

  function automatic estimate_t filter_step(mode_e mode, longint value, logic [15:0] step,
                                            logic [47:0] mvar);
    estimate_t   e;
    logic [63:0] d;
    logic        ok;
    d  = (step < StepMin) ? StepMin : ((step > StepMax) ? StepMax : step);
    ok = 1'b0;
    case (mode)
      MODE_PREDICT: begin
        propagate(value, d);
        ok = 1'b1;
      end
      MODE_POS: ok = measure(1'b0, value, mvar);
      MODE_VEL: ok = measure(1'b1, value, mvar);
      default: ok = 1'b0;
    endcase
    e.pos     = pos_q[31:0];
    e.vel     = vel_q[31:0];
    e.pos_var = p00_q[47:0];
    e.vel_var = p11_q[47:0];
    e.ok      = ok;
    return e;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    estimate_t e;
    logic [VarW-1:0] v;
    if (!rst_ni) begin
      estimate_q.delete();
      errors = 0;
      accel_noise = AccelNzRst;
      drift_noise = '0;
      gate        = GateRst;
      pos_q = 0;
      vel_q = 0;
      p00_q = longint'(InitVarRst);
      p11_q = longint'(InitVarRst);
      p01_q = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ACCEL_NOISE: accel_noise = cfg_wdata_i;
          CFG_POS_DRIFT:   drift_noise = cfg_wdata_i;
          CFG_GATE:        gate = cfg_wdata_i[GateW-1:0];
          default: begin
            v = (cfg_wdata_i < VarFloor) ? VarFloor : cfg_wdata_i;
            p00_q = longint'(v);
            p11_q = longint'(v);
            p01_q = 0;
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (estimate_q.size() == 0) begin
          $display("result beat with no item outstanding");
          errors++;
        end else begin
          e = estimate_q.pop_front();
          if (pos_est_i !== e.pos)
            report("pos_est", longint'(pos_est_i), longint'(signed'(e.pos)));
          if (vel_est_i !== e.vel)
            report("vel_est", longint'(vel_est_i), longint'(signed'(e.vel)));
          if (pos_var_out_i !== e.pos_var)
            report("pos_var_out", longint'(pos_var_out_i), longint'(e.pos_var));
          if (vel_var_out_i !== e.vel_var)
            report("vel_var_out", longint'(vel_var_out_i), longint'(e.vel_var));
          if (accepted_i !== e.ok)
            report("accepted", longint'(accepted_i), longint'(e.ok));
        end
      end
      if (in_valid_i && !in_stall_i)
        estimate_q.push_back(filter_step(mode_e'(mode_i), longint'(value_i), step_time_i,
                                         meas_var_i));
    end
  end

endmodule

// File: verif/kalman_axis_pos_vel_filter_unit_test.sv
// ---------------------------------------------------------------------------
// kalman_axis_pos_vel_filter_unit_test: stimulus for the axis filter
// Directed beats at the field extremes, then phases of random predictions
// and gated measurements under several register settings, with random
// idling on both channels, a long output hold-off and a full drain.
// ---------------------------------------------------------------------------
module kalman_axis_pos_vel_filter_unit_test;
  import kpv_pkg::*;

  localparam int IdleLimit = 30000;
  localparam int HoldCycles = 2500;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgDataW-1:0]    cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [ModeW-1:0]       mode_i = '0;
  logic signed [PosW-1:0] value_i = '0;
  logic [StepW-1:0]       step_time_i = '0;
  logic [VarW-1:0]        meas_var_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [PosW-1:0] pos_est_o, vel_est_o;
  logic [VarW-1:0]        pos_var_out_o, vel_var_out_o;
  logic                   accepted_o;

  int   pending, errors;
  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;
  int   idle_cycles = 0;
  int   n_predict = 0, n_meas = 0, n_unused = 0, n_ok = 0;
  logic signed [PosW-1:0] last_pos = '0, last_vel = '0;

  kalman_axis_pos_vel_filter_unit dut (.*);

  kalman_axis_pos_vel_filter_unit_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .value_i, .step_time_i, .meas_var_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pos_est_i(pos_est_o), .vel_est_i(vel_est_o),
    .pos_var_out_i(pos_var_out_o), .vel_var_out_i(vel_var_out_o), .accepted_i(accepted_o),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      last_pos <= pos_est_o;
      last_vel <= vel_est_o;
      if (accepted_o) n_ok <= n_ok + 1;
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("kalman_axis_pos_vel_filter_unit_test NOT OK");
      $finish;
    end
  end

  // Receiver side: random stall bursts and one long hold-off on request.
  initial begin : receiver
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(mode_e mode, logic [31:0] value, logic [15:0] step, logic [47:0] mvar);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    value_i     <= value;
    step_time_i <= step;
    meas_var_i  <= mvar;
    case (mode)
      MODE_PREDICT: n_predict++;
      MODE_NONE:    n_unused++;
      default:      n_meas++;
    endcase
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
  endtask

  // The first edge lets the scoreboard log the beat accepted just before.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  // Mostly plausible sequences: modest accelerations and measurements close
  // to the last estimate, so that corrections pass the gate and move the state.
  task automatic rand_item();
    int          pick;
    logic [31:0] v;
    logic [15:0] st;
    logic [47:0] mv;
    pick = $urandom_range(0, 99);
    st = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(105, 52429));
    mv = ($urandom_range(0, 7) == 0) ? rand48() : (rand48() >> $urandom_range(12, 40));
    if (pick < 40) begin
      v = ($urandom_range(0, 9) == 0) ? $urandom
                                      : 32'(signed'($urandom_range(0, 1 << 19)) - (1 << 18));
      send(MODE_PREDICT, v, st, mv);
    end else if (pick < 85) begin
      v = 32'(signed'($urandom_range(0, 1 << 15)) - (1 << 14));
      if (pick < 62) send(MODE_POS, last_pos + v, st, mv);
      else send(MODE_VEL, last_vel + v, st, mv);
    end else if (pick < 96) begin
      send(($urandom_range(0, 1) != 0) ? MODE_POS : MODE_VEL, $urandom, st, rand48());
    end else begin
      send(MODE_NONE, $urandom, 16'($urandom), rand48());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings.
    send(MODE_PREDICT, 32'h7FFF_FFFF, 16'd0, '0);
    send(MODE_PREDICT, 32'h8000_0000, 16'hFFFF, '1);
    send(MODE_PREDICT, 32'd0, 16'd105, '0);
    send(MODE_PREDICT, 32'h0001_0000, 16'd52429, '0);
    send(MODE_POS, 32'd0, 16'd0, '0);
    send(MODE_POS, 32'h7FFF_FFFF, 16'd0, 48'd1);
    send(MODE_VEL, 32'h8000_0000, 16'd0, '1);
    send(MODE_VEL, 32'h0000_8000, 16'd0, 48'h1_0000_0000);
    send(MODE_NONE, 32'h1234_5678, 16'd7, '1);
    send(MODE_POS, 32'h8000_0000, 16'hFFFF, '1);
    drain();
    // A zero gate passes only a measurement that matches the estimate.
    cfg_write(CFG_GATE, 48'd0);
    send(MODE_POS, last_pos + 1, 16'd0, 48'h1_0000);
    drain();
    send(MODE_POS, last_pos, 16'd0, 48'h1_0000);
    send(MODE_VEL, last_vel, 16'd0, 48'h1_0000);
    drain();

    cfg_write(CFG_ACCEL_NOISE, 48'd1 << 28);
    cfg_write(CFG_POS_DRIFT, 48'd1 << 20);
    cfg_write(CFG_GATE, 48'd2304);
    cfg_write(CFG_INIT_VAR, 48'd1 << 32);
    repeat (100) rand_item();
    // Hold the result side off while the sender keeps offering beats.
    hold_req <= 1'b1;
    repeat (6) rand_item();
    repeat (100) rand_item();
    drain();

    cfg_write(CFG_ACCEL_NOISE, 48'd0);
    cfg_write(CFG_POS_DRIFT, 48'd0);
    cfg_write(CFG_GATE, 48'hFFFF);
    cfg_write(CFG_INIT_VAR, 48'd0);
    repeat (50) rand_item();
    drain();
    repeat (50) rand_item();
    drain();

    cfg_write(CFG_ACCEL_NOISE, '1);
    cfg_write(CFG_POS_DRIFT, '1);
    cfg_write(CFG_GATE, 48'd1);
    cfg_write(CFG_INIT_VAR, '1);
    repeat (80) rand_item();
    drain();

    cfg_write(CFG_ACCEL_NOISE, 48'd1073741824);
    cfg_write(CFG_POS_DRIFT, 48'd4096);
    cfg_write(CFG_GATE, 48'd2304);
    cfg_write(CFG_INIT_VAR, 48'd1 << 30);
    repeat (100) rand_item();
    gaps_on <= 1'b0;
    repeat (120) rand_item();
    drain();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d predictions, %0d measurements and %0d unused-mode beats",
             n_predict, n_meas, n_unused);
    $display("over four register settings; %0d results reported acceptance.", n_ok);
    if (errors == 0) begin
      $display("kalman_axis_pos_vel_filter_unit_test OK");
    end else begin
      $display("kalman_axis_pos_vel_filter_unit_test NOT OK");
    end
    $finish;
  end

endmodule
